/* rtl/core/rcwt_pkg.sv */
package rcwt_pkg;

	// default texture edge length and fixed face count
	localparam int TEX_DIM_DEF = 64;
	localparam int FACE_COUNT  = 4;
	localparam int FACE_W      = 2;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
	localparam logic [1:0] REG_PLAYER_X      = 2'd1;
	localparam logic [1:0] REG_PLAYER_Y      = 2'd2;

	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;

	// input item
	typedef struct packed {
		logic [1:0]         command;
		logic [1:0]         face;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic [30:0]        perp_dist;
		logic [15:0]        line_height;
		logic [10:0]        draw_start;
		logic [10:0]        draw_end;
		logic [10:0]        column_x;
		logic [11:0]        texel_addr;
		logic [31:0]        texel_color;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [10:0] screen_x;
		logic [10:0] screen_y;
		logic [31:0] pixel_color;
		logic        last_row;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_en;
		logic start_en;
		logic tick_en;
		logic hit_en;
		logic div_step;
		logic div_first;
		logic pmul_en;
		logic pos_en;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tick_ok;
	} ctrl_sts_t;

endpackage

/* rtl/core/rcwt_ram.sv */
module rcwt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read that holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/rcwt_ctrl.sv */
module rcwt_ctrl #(
	parameter int TEX_DIM = rcwt_pkg::TEX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  rcwt_pkg::ctrl_sts_t sts,
	output rcwt_pkg::ctrl_cmd_t cmd
);

	localparam int TW = $clog2(TEX_DIM);
	localparam int QW = TW + 17;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HIT  = 5'b00010,
		S_DIV  = 5'b00100,
		S_PMUL = 5'b01000,
		S_POS  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          idle;
	logic          accept;

	// item acceptance
	assign idle     = (state_q == S_IDLE);
	assign in_ready = idle && ((command != rcwt_pkg::CMD_TICK) || sts.tick_ok);
	assign accept   = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.load_en   = accept && (command == rcwt_pkg::CMD_LOAD);
		cmd.start_en  = accept && (command == rcwt_pkg::CMD_START);
		cmd.tick_en   = accept && (command == rcwt_pkg::CMD_TICK);
		cmd.hit_en    = (state_q == S_HIT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.div_first = (state_q == S_DIV) && (cnt_q == CNT_TOP);
		cmd.pmul_en   = (state_q == S_PMUL);
		cmd.pos_en    = (state_q == S_POS);
	end

	// column setup sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start_en) begin
						state_q <= S_HIT;
					end
				end
				S_HIT: begin
					state_q <= S_DIV;
					cnt_q   <= CNT_TOP;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_PMUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_PMUL: begin
					state_q <= S_POS;
				end
				S_POS: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/rcwt_dp.sv */
module rcwt_dp #(
	parameter int TEX_DIM = rcwt_pkg::TEX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcwt_pkg::in_item_t  in_item,
	input  rcwt_pkg::ctrl_cmd_t cmd,
	output rcwt_pkg::ctrl_sts_t sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rcwt_pkg::out_item_t out_item
);

	localparam int TW    = $clog2(TEX_DIM);
	localparam int QW    = TW + 17;
	localparam int PW    = QW + 17;
	localparam int AW    = rcwt_pkg::FACE_W + 2 * TW;
	localparam int DEPTH = rcwt_pkg::FACE_COUNT * TEX_DIM * TEX_DIM;
	localparam int XW    = (2 * TW > 12) ? 2 * TW : 12;
	localparam logic [31:0] POS_MAX = 32'({{TW{1'b1}}, 16'd0});

	// configuration registers
	logic [10:0] sh_q;
	logic [31:0] px_q;
	logic [31:0] py_q;

	// column state
	logic [TW-1:0] col_q;
	logic [31:0]   step_q;
	logic [31:0]   pos_q;
	logic [10:0]   row_q;
	logic [10:0]   end_q;
	logic [10:0]   colx_q;
	logic [1:0]    face_q;
	logic          active_q;

	// setup datapath
	logic               mirror_q;
	logic [15:0]        divisor_q;
	logic signed [18:0] a_q;
	logic [15:0]        hprod_s1;
	logic [15:0]        rem_q;
	logic [QW-1:0]      quo_q;
	logic [PW-1:0]      prod_q;

	// read pipeline and output
	logic        rd_pend_q;
	logic [10:0] rd_x_s1;
	logic [10:0] rd_y_s1;
	logic        rd_last_s1;
	logic        out_valid_q;
	rcwt_pkg::out_item_t out_q;

	logic               ns;
	logic [31:0]        dir_sel;
	logic [31:0]        hprod;
	logic [15:0]        lh_fix;
	logic signed [18:0] a_c;
	logic               mirror_c;
	logic [15:0]        hit16;
	logic [16:0]        trial;
	logic               ge;
	logic [16:0]        a_pos;
	logic [PW-2:0]      half;
	logic [TW-1:0]      ty;
	logic [31:0]        pos_clip;
	logic [11:0]        row_nx;
	logic               last;
	logic               tick_fire;
	logic               move;
	logic [XW-1:0]      addr_x;
	logic               in_range;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [31:0]        rdata;

	// start operands
	assign ns       = !in_item.face[1];
	assign dir_sel  = ns ? in_item.dir_y : in_item.dir_x;
	assign hprod    = 32'({1'b0, in_item.perp_dist}) * dir_sel;
	assign lh_fix   = (in_item.line_height == '0) ? 16'd1 : in_item.line_height;
	assign a_c      = $signed({7'd0, in_item.draw_start, 1'b0}) - $signed({8'd0, sh_q})
	                  + $signed({3'd0, lh_fix});
	assign mirror_c = ns ? (!in_item.dir_x[31] && (in_item.dir_x != '0)) : in_item.dir_y[31];

	// fractional hit and texture column
	assign hit16 = (face_q[1] ? px_q[15:0] : py_q[15:0]) + hprod_s1;

	// one restoring division step, dividend is a single set bit
	assign trial = {rem_q, cmd.div_first};
	assign ge    = trial >= {1'b0, divisor_q};

	// start position
	assign a_pos = (!a_q[18] && (a_q != '0)) ? a_q[16:0] : '0;
	assign half  = prod_q[PW-1:1];

	// row tick
	assign ty        = (pos_q[31:16+TW] != '0) ? {TW{1'b1}} : pos_q[16 +: TW];
	assign pos_clip  = (pos_q > POS_MAX) ? POS_MAX : pos_q;
	assign row_nx    = {1'b0, row_q} + 12'd1;
	assign last      = row_nx >= {1'b0, end_q};
	assign tick_fire = cmd.tick_en && active_q && (row_q < end_q);
	assign move      = rd_pend_q && (!out_valid_q || out_ready);
	assign sts.tick_ok = !rd_pend_q || !out_valid_q || out_ready;

	// texture store addressing
	assign addr_x   = XW'(in_item.texel_addr);
	assign in_range = (addr_x >> (2 * TW)) == '0;
	assign waddr    = {in_item.face, addr_x[2*TW-1:0]};
	assign raddr    = {face_q, ty, col_q};

	rcwt_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_tex (
		.clk  (clk),
		.we   (cmd.load_en && in_range),
		.waddr(waddr),
		.wdata(in_item.texel_color),
		.re   (tick_fire),
		.raddr(raddr),
		.rdata(rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= rcwt_pkg::SCREEN_HEIGHT_RST;
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rcwt_pkg::REG_SCREEN_HEIGHT: sh_q <= cfg_data[10:0];
				rcwt_pkg::REG_PLAYER_X:      px_q <= cfg_data;
				rcwt_pkg::REG_PLAYER_Y:      py_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// column state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			step_q   <= '0;
			pos_q    <= '0;
			row_q    <= '0;
			end_q    <= '0;
			colx_q   <= '0;
			face_q   <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.start_en) begin
				face_q   <= in_item.face;
				colx_q   <= in_item.column_x;
				row_q    <= in_item.draw_start;
				end_q    <= in_item.draw_end;
				active_q <= in_item.draw_start < in_item.draw_end;
			end
			if (cmd.hit_en) begin
				col_q <= hit16[15 -: TW] ^ {TW{mirror_q}};
			end
			if (cmd.pos_en) begin
				step_q <= 32'(quo_q);
				pos_q  <= (half > (PW-1)'(POS_MAX)) ? POS_MAX : 32'(half);
			end
			if (tick_fire) begin
				pos_q <= pos_clip + step_q;
				row_q <= row_nx[10:0];
				if (last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// setup arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.start_en) begin
			mirror_q  <= mirror_c;
			divisor_q <= lh_fix;
			a_q       <= a_c;
			hprod_s1  <= hprod[31:16];
			rem_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? 16'(trial - {1'b0, divisor_q}) : trial[15:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (cmd.pmul_en) begin
			prod_q <= PW'(a_pos) * PW'(quo_q);
		end
	end

	// pending texel read and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_fire) begin
				rd_pend_q <= 1'b1;
			end else if (move) begin
				rd_pend_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			rd_x_s1    <= colx_q;
			rd_y_s1    <= row_q;
			rd_last_s1 <= last;
		end
		if (move) begin
			out_q.screen_x    <= rd_x_s1;
			out_q.screen_y    <= rd_y_s1;
			out_q.pixel_color <= rdata;
			out_q.last_row    <= rd_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/core/raycast_wall_texture_column.sv */
// channel | signals                       | direction | accepted when
// in      | in_valid, in_ready, in_item   | input     | in_valid && in_ready
// out     | out_valid, out_ready, out_item| output    | out_valid && out_ready
// cfg     | cfg_we, cfg_idx, cfg_data     | input     | cfg_we
//
// load and row tick items are accepted without a setup sequence; a row tick's pixel
// passes the registered texel read and then leaves the output register.
// a start item holds the input through the hit step, the step division at one bit
// per cycle, and the position multiply and clamp steps.
// reset clears all control and column state; the texture store is not cleared.
// a stalled output holds one pixel and one pending read before ticks are refused.
module raycast_wall_texture_column #(
	parameter int TEX_DIM = rcwt_pkg::TEX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rcwt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rcwt_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data
);

	rcwt_pkg::ctrl_cmd_t cmd;
	rcwt_pkg::ctrl_sts_t sts;

	// sequencer
	rcwt_ctrl #(
		.TEX_DIM(TEX_DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (in_item.command),
		.sts     (sts),
		.cmd     (cmd)
	);

	// arithmetic, column state and texture store
	rcwt_dp #(
		.TEX_DIM(TEX_DIM)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// at most one sequencer action per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_en, cmd.start_en, cmd.tick_en, cmd.hit_en, cmd.div_step,
			cmd.pmul_en, cmd.pos_en}))
		else $error("more than one datapath command active");

	// a start item blocks the input while the column is set up
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_item.command == rcwt_pkg::CMD_START)) |=> !in_ready)
		else $error("input accepted during column setup");

	// position is written right after the position multiply
	a_pos_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pos_en |-> $past(cmd.pmul_en))
		else $error("position clamp without multiply");

	// division always runs straight after the hit step
	a_div_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_en |=> cmd.div_first)
		else $error("division did not start after hit step");

endmodule

/* test/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcwt_pkg::*;

	localparam int TEX = TEX_DIM_DEF;
	localparam int TW = $clog2(TEX);
	localparam longint POS_MAX = longint'(TEX - 1) << 16;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int SETTLE = 40;
	localparam int LIMIT = 4000;

	typedef struct {
		in_item_t  item;
		bit        typed;
		bit        has_pix;
		out_item_t pix;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_ready = 1'b1;
	out_item_t  out_item;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	// predictor state
	logic [31:0] tex_mem [0:FACE_COUNT*TEX*TEX-1];
	bit          tex_ok [0:FACE_COUNT*TEX*TEX-1];
	logic [TW-1:0] t_col = '0;
	logic [31:0] t_step = '0;
	logic [31:0] t_pos = '0;
	logic [10:0] row_now = '0;
	logic [10:0] row_end = '0;
	logic [10:0] col_x = '0;
	logic [1:0]  face_now = '0;
	bit          col_live = 1'b0;
	logic [10:0] cfg_height = SCREEN_HEIGHT_RST;
	logic [31:0] cfg_px = '0;
	logic [31:0] cfg_py = '0;

	out_item_t pixels_due [$];
	plan_row_t plan [$];
	int faults = 0;
	int send_idle = 0;
	int stall_pct = 0;
	int quiet = 0;
	int sent = 0;

	// what the driver says about the item on the bus right now
	bit        row_typed = 1'b0;
	bit        row_has = 1'b0;
	out_item_t row_pix = '0;

	raycast_wall_texture_column uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// expected pixel for one item; updates the column state
	function automatic bit render_item(input in_item_t it, output out_item_t pix);
		bit ns;
		bit last;
		logic signed [63:0] dir64;
		logic signed [63:0] prod;
		logic [31:0] hit;
		logic [TW-1:0] col;
		logic [TW-1:0] ty;
		logic [15:0] lh;
		logic [31:0] np;
		longint a;
		longint p;
		pix = '0;
		render_item = 1'b0;
		case (it.command)
			CMD_LOAD: begin
				tex_mem[{it.face, it.texel_addr}] = it.texel_color;
				tex_ok[{it.face, it.texel_addr}] = 1'b1;
			end
			CMD_START: begin
				ns = (it.face < 2);
				dir64 = ns ? {{32{it.dir_y[31]}}, it.dir_y} : {{32{it.dir_x[31]}}, it.dir_x};
				prod = $signed({33'd0, it.perp_dist}) * dir64;
				hit = (ns ? cfg_py : cfg_px) + prod[47:16];
				col = hit[15:16-TW];
				// mirror so the texture reads left to right on every face
				if ((ns && $signed(it.dir_x) > 0) || (!ns && $signed(it.dir_y) < 0)) begin
					col = TW'(TEX - 1) - col;
				end
				lh = (it.line_height == 16'd0) ? 16'd1 : it.line_height;
				t_step = 32'((64'(TEX) << 16) / lh);
				a = 2 * longint'(it.draw_start) - longint'(cfg_height) + longint'(lh);
				p = a * longint'(t_step);
				if (p < 0) begin
					p = 0;
				end
				p = p / 2;
				if (p > POS_MAX) begin
					p = POS_MAX;
				end
				t_pos = 32'(p);
				t_col = col;
				face_now = it.face;
				col_x = it.column_x;
				row_now = it.draw_start;
				row_end = it.draw_end;
				col_live = (it.draw_start < it.draw_end);
			end
			CMD_TICK: begin
				if (col_live && row_now < row_end) begin
					if (t_pos[31:16] > TEX - 1) begin
						ty = TW'(TEX - 1);
					end else begin
						ty = t_pos[16 +: TW];
					end
					np = (t_pos > POS_MAX) ? 32'(POS_MAX) : t_pos;
					t_pos = np + t_step;
					last = ({1'b0, row_now} + 12'd1 >= {1'b0, row_end});
					pix = {col_x, row_now, tex_mem[{face_now, ty, t_col}], last};
					row_now = row_now + 11'd1;
					if (last) begin
						col_live = 1'b0;
					end
					render_item = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// texel the next tick would read, when it has never been loaded
	function automatic bit tick_texel(output logic [FACE_W+2*TW-1:0] idx);
		logic [TW-1:0] ty;
		ty = (t_pos[31:16] > TEX - 1) ? TW'(TEX - 1) : t_pos[16 +: TW];
		idx = {face_now, ty, t_col};
		return col_live && (row_now < row_end) && !tex_ok[idx];
	endfunction

	task automatic note_fault(input string msg);
		faults++;
		if (faults <= 10) begin
			$display("%s", msg);
		end
	endtask

	// register shadow, prediction on accept, pixel check
	always @(posedge clk) begin : track
		out_item_t pix;
		out_item_t want;
		bit made;
		if (cfg_we) begin
			case (cfg_idx)
				REG_SCREEN_HEIGHT: cfg_height = cfg_data[10:0];
				REG_PLAYER_X:      cfg_px = cfg_data;
				REG_PLAYER_Y:      cfg_py = cfg_data;
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			made = render_item(in_item, pix);
			if (row_typed) begin
				if (row_has) begin
					pixels_due.push_back(row_pix);
				end
			end else if (made) begin
				pixels_due.push_back(pix);
			end
		end
		if (out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				note_fault($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%0b",
					out_item.screen_x, out_item.screen_y, out_item.pixel_color,
					out_item.last_row));
			end else begin
				want = pixels_due.pop_front();
				if (out_item.screen_x !== want.screen_x || out_item.screen_y !== want.screen_y
						|| out_item.pixel_color !== want.pixel_color
						|| out_item.last_row !== want.last_row) begin
					note_fault($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%h ",
						"last=%0b, got x=%0d y=%0d color=%h last=%0b"},
						want.screen_x, want.screen_y, want.pixel_color, want.last_row,
						out_item.screen_x, out_item.screen_y, out_item.pixel_color,
						out_item.last_row));
				end
			end
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
		end
		if (quiet == LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic in_item_t mk(input logic [1:0] cmd, input logic [1:0] face,
			input logic [31:0] dx, input logic [31:0] dy, input logic [30:0] perp,
			input logic [15:0] lh, input logic [10:0] ds, input logic [10:0] de,
			input logic [10:0] colx, input logic [11:0] addr, input logic [31:0] color);
		in_item_t it;
		it.command = cmd;
		it.face = face;
		it.dir_x = dx;
		it.dir_y = dy;
		it.perp_dist = perp;
		it.line_height = lh;
		it.draw_start = ds;
		it.draw_end = de;
		it.column_x = colx;
		it.texel_addr = addr;
		it.texel_color = color;
		return it;
	endfunction

	function automatic in_item_t rand_item();
		return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	function automatic void add_row(input in_item_t it, input bit typed, input bit has,
			input out_item_t pix);
		plan_row_t row;
		row.item = it;
		row.typed = typed;
		row.has_pix = has;
		row.pix = pix;
		plan.push_back(row);
	endfunction

	// drive one item from a falling edge on and wait for it to be taken
	task automatic present(input in_item_t it, input bit typed, input bit has,
			input out_item_t pix);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_has = has;
		row_pix = pix;
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// present one item; a tick gets its texel loaded first when it has none yet
	task automatic send(input in_item_t it, input bit typed, input bit has,
			input out_item_t pix);
		logic [FACE_W+2*TW-1:0] idx;
		@(negedge clk);
		if (it.command == CMD_TICK && tick_texel(idx)) begin
			present(mk(CMD_LOAD, idx[2*TW +: FACE_W], 0, 0, 0, 0, 0, 0, 0,
				12'(idx[2*TW-1:0]), $urandom()), 1'b0, 1'b0, '0);
			@(negedge clk);
		end
		present(it, typed, has, pix);
	endtask

	// hold off until every pixel is back and the block has settled
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_view(input logic [10:0] h, input logic [31:0] px,
			input logic [31:0] py);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SCREEN_HEIGHT;
		cfg_data <= {21'd0, h};
		@(negedge clk);
		cfg_idx <= REG_PLAYER_X;
		cfg_data <= px;
		@(negedge clk);
		cfg_idx <= REG_PLAYER_Y;
		cfg_data <= py;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly whole columns with random content, some loads, noise and cut columns
	task automatic drive_mix(input int budget);
		in_item_t it;
		int stop;
		int r;
		int span;
		int ticks;
		int k;
		stop = sent + budget;
		while (sent < stop) begin
			r = $urandom_range(99);
			it = rand_item();
			if (r < 6) begin
				it.command = CMD_LOAD;
				send(it, 1'b0, 1'b0, '0);
			end else if (r < 9) begin
				it.command = CMD_NOP;
				send(it, 1'b0, 1'b0, '0);
			end else if (r < 12) begin
				it.command = CMD_TICK;
				send(it, 1'b0, 1'b0, '0);
			end else begin
				it.command = CMD_START;
				if ($urandom_range(99) < 50) begin
					it.dir_x = $urandom_range(0, 262144) - 131072;
				end
				if ($urandom_range(99) < 50) begin
					it.dir_y = $urandom_range(0, 262144) - 131072;
				end
				if ($urandom_range(99) < 50) begin
					it.perp_dist = 31'($urandom_range(0, 1 << 22));
				end
				r = $urandom_range(99);
				if (r < 50) begin
					it.line_height = 16'($urandom_range(1, 700));
				end else if (r < 60) begin
					it.line_height = 16'($urandom_range(0, 3));
				end
				r = $urandom_range(99);
				if (r < 85) begin
					span = $urandom_range(1, 16);
				end else if (r < 95) begin
					span = $urandom_range(17, 120);
				end else begin
					span = 0;
				end
				if (span == 0) begin
					it.draw_end = 11'($urandom_range(0, it.draw_start));
				end else if (int'(it.draw_start) + span > 2047) begin
					it.draw_end = 11'd2047;
				end else begin
					it.draw_end = it.draw_start + 11'(span);
				end
				ticks = (it.draw_end > it.draw_start) ? int'(it.draw_end - it.draw_start) : 0;
				r = $urandom_range(99);
				if (r < 5 && ticks > 1) begin
					ticks = $urandom_range(1, ticks - 1);
				end else if (r < 10) begin
					ticks++;
				end
				send(it, 1'b0, 1'b0, '0);
				for (k = 0; k < ticks; k++) begin
					it = rand_item();
					it.command = CMD_TICK;
					send(it, 1'b0, 1'b0, '0);
				end
			end
		end
	endtask

	initial begin
		int i;
		int ph;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows; typed rows carry the pixel by hand
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0);
		add_row(mk(CMD_NOP, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1, 0, '0);
		add_row(mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 12'd0, 32'hDEAD_BEEF), 1, 0, '0);
		add_row(mk(CMD_LOAD, 3, 0, 0, 0, 0, 0, 0, 0, 12'd4095, 32'hFFFF_FFFF), 1, 0, '0);
		add_row(mk(CMD_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 12'd0, 32'h0), 1, 0, '0);
		// flat hit, step of one texel per row, single row
		add_row(mk(CMD_START, 0, 0, 0, 0, 16'd64, 11'd208, 11'd209, 0, 0, 0), 1, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
			{11'd0, 11'd208, 32'hDEAD_BEEF, 1'b1});
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0);
		// hit just below a boundary picks the last column, clamped position the last row
		add_row(mk(CMD_START, 3, 32'hFFFF_FFFF, 0, 31'd1024, 16'd1, 11'd2046, 11'd2047,
			11'd2047, 0, 0), 1, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
			{11'd2047, 11'd2046, 32'hFFFF_FFFF, 1'b1});
		// zero line height, extreme directions and distance
		add_row(mk(CMD_START, 1, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'd0,
			11'd0, 11'd3, 11'd5, 0, 0), 0, 0, '0);
		for (i = 0; i < 3; i++) begin
			add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);
		end
		// east/west mirrored by negative y direction, tallest line
		add_row(mk(CMD_START, 2, 32'h8000_0000, -32'sd5, 31'h10000, 16'hFFFF,
			11'd100, 11'd102, 11'd77, 0, 0), 0, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);
		// empty and reversed spans leave no column
		add_row(mk(CMD_START, 0, 0, 0, 0, 16'd64, 11'd5, 11'd5, 0, 0, 0), 1, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0);
		add_row(mk(CMD_START, 0, 0, 0, 0, 16'd64, 11'd2047, 11'd0, 0, 0, 0), 1, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0);
		// north/south mirrored by positive x direction
		add_row(mk(CMD_START, 1, 32'd1, 32'h18000, 31'h20000, 16'd480, 11'd0, 11'd2,
			11'd9, 0, 0), 0, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);
		add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);

		// the idle tick goes first; texels are loaded as the ticks need them
		for (i = 0; i < plan.size(); i++) begin
			send(plan[i].item, plan[i].typed, plan[i].has_pix, plan[i].pix);
		end

		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					send_idle = 0;
					stall_pct = 0;
					set_view(11'd2047, 32'h7FFF_FFFF, 32'h8000_0000);
				end
				1: begin
					send_idle = 78;
					stall_pct = 0;
					set_view(11'd1, 32'h8000_0000, 32'h7FFF_FFFF);
				end
				2: begin
					send_idle = 0;
					stall_pct = 78;
					set_view(11'($urandom_range(1, 2047)), $urandom(), $urandom());
				end
				default: begin
					send_idle = 37;
					stall_pct = 37;
					set_view(11'd480, $urandom(), $urandom());
				end
			endcase
			drive_mix(425);
		end
		drain();

		if (faults == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
